// File: rtl/bll_pkg.sv
// ============================================================================
// bll_pkg: shared constants and types of the bounded linked list engine
// Sizes, command and status codes, and the request/response bundles that
// pass between the sequencer and the node store.
// ============================================================================
`default_nettype none

package bll_pkg;

    // Node store size and derived widths
    localparam int DEPTH = 64;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    // Fixed field widths
    localparam int OP_W  = 3;
    localparam int VAL_W = 16;
    localparam int POS_W = 6;
    localparam int ST_W  = 2;
    localparam int LEN_W = 7;

    // Command codes
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE     = 3'd3;
    localparam logic [OP_W-1:0] OP_CONTAINS   = 3'd4;
    localparam logic [OP_W-1:0] OP_GET        = 3'd5;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_MISS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;

    // Sequencer to node store
    typedef struct packed {
        logic [AW-1:0]    rd_addr;
        logic             val_we;
        logic [AW-1:0]    val_addr;
        logic [VAL_W-1:0] val_data;
        logic             lnk_we;
        logic [AW-1:0]    lnk_addr;
        logic [AW-1:0]    lnk_data;
    } t_store_req;

    // Node store to sequencer: registered read of the node at rd_addr
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [AW-1:0]    link;
    } t_store_rsp;

endpackage

`default_nettype wire

// File: rtl/bounded_linked_list_engine.sv
// ============================================================================
// bounded_linked_list_engine: ordered list of signed 16-bit values
// Pulse start while busy is low to issue one request (push back, push front,
// pop front, remove value, contains, get at position). Exactly one result
// follows, shown for a single cycle with o_done high; the receiver cannot
// stall it, so capture it on that cycle. A request refused up front (push
// when full, pop or search on an empty list, get out of range, undefined
// code) answers in the next cycle. Push runs through S_PUSH, pop through
// S_POP and S_FREE; contains and get walk in S_WALK to the matching node,
// remove then runs through S_FREE too; a miss walks the whole list. The single
// read port of the node store yields one node per cycle in the walk, and its
// registered link feeds the next read address. busy stays high until the
// result cycle, and a new request may be issued in the result cycle itself.
// ============================================================================
`default_nettype none

module bounded_linked_list_engine (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    start,
    output logic                                   busy,
    input  wire        [bll_pkg::OP_W-1:0]         i_operation,
    input  wire signed [bll_pkg::VAL_W-1:0]        i_value,
    input  wire        [bll_pkg::POS_W-1:0]        i_position,
    output logic                                   o_done,
    output logic       [bll_pkg::ST_W-1:0]         o_status,
    output logic signed [bll_pkg::VAL_W-1:0]       o_read_value,
    output logic       [bll_pkg::LEN_W-1:0]        o_length
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PUSH = 5'b00010,
        S_POP  = 5'b00100,
        S_WALK = 5'b01000,
        S_FREE = 5'b10000
    } t_state;

    t_state                     r_state, n_state;
    logic [bll_pkg::OP_W-1:0]   r_op,    n_op;
    logic [bll_pkg::VAL_W-1:0]  r_val,   n_val;
    logic [bll_pkg::POS_W-1:0]  r_pos,   n_pos;
    logic [bll_pkg::AW-1:0]     r_head,  n_head;
    logic [bll_pkg::AW-1:0]     r_tail,  n_tail;
    logic [bll_pkg::AW-1:0]     r_free,  n_free;
    logic [bll_pkg::CW-1:0]     r_count, n_count;
    logic [bll_pkg::AW-1:0]     r_slot,  n_slot;
    logic [bll_pkg::AW-1:0]     r_prev,  n_prev;
    logic [bll_pkg::AW-1:0]     r_idx,   n_idx;
    logic                       r_done,  n_done;
    logic [bll_pkg::ST_W-1:0]   r_status, n_status;
    logic [bll_pkg::VAL_W-1:0]  r_rv,    n_rv;

    bll_pkg::t_store_req        w_req;
    bll_pkg::t_store_rsp        w_rsp;
    logic                       w_match;
    logic [bll_pkg::CW-1:0]     w_idx_inc;

    bll_node_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Walk compare: get matches on position, remove and contains on value
    assign w_idx_inc = bll_pkg::CW'(r_idx) + bll_pkg::CW'(1);
    assign w_match   = (r_op == bll_pkg::OP_GET)
                     ? (bll_pkg::CW'(r_idx) == bll_pkg::CW'(r_pos))
                     : (w_rsp.value == r_val);

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_val    = r_val;
        n_pos    = r_pos;
        n_head   = r_head;
        n_tail   = r_tail;
        n_free   = r_free;
        n_count  = r_count;
        n_slot   = r_slot;
        n_prev   = r_prev;
        n_idx    = r_idx;
        n_done   = 1'b0;
        n_status = r_status;
        n_rv     = r_rv;

        // Default read: follow the link of the node just read
        w_req          = '0;
        w_req.rd_addr  = w_rsp.link;

        case (r_state)
            S_IDLE: begin
                // Fetch the free slot for a push, the head otherwise
                if (i_operation == bll_pkg::OP_PUSH_BACK ||
                    i_operation == bll_pkg::OP_PUSH_FRONT) begin
                    w_req.rd_addr = r_free;
                end else begin
                    w_req.rd_addr = r_head;
                end
                if (start) begin
                    n_op   = i_operation;
                    n_val  = i_value;
                    n_pos  = i_position;
                    n_slot = r_head;
                    n_prev = r_head;
                    n_idx  = '0;
                    n_rv   = '0;
                    case (i_operation)
                        bll_pkg::OP_PUSH_BACK, bll_pkg::OP_PUSH_FRONT: begin
                            if (r_count >= bll_pkg::CW'(bll_pkg::DEPTH)) begin
                                n_done   = 1'b1;
                                n_status = bll_pkg::ST_FULL;
                            end else begin
                                n_state = S_PUSH;
                            end
                        end
                        bll_pkg::OP_POP_FRONT: begin
                            if (r_count == '0) begin
                                n_done   = 1'b1;
                                n_status = bll_pkg::ST_MISS;
                            end else begin
                                n_state = S_POP;
                            end
                        end
                        bll_pkg::OP_REMOVE, bll_pkg::OP_CONTAINS: begin
                            if (r_count == '0) begin
                                n_done   = 1'b1;
                                n_status = bll_pkg::ST_MISS;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        bll_pkg::OP_GET: begin
                            if (bll_pkg::CW'(i_position) >= r_count) begin
                                n_done   = 1'b1;
                                n_status = bll_pkg::ST_MISS;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        default: begin
                            // Undefined code: answer and leave the list alone
                            n_done   = 1'b1;
                            n_status = bll_pkg::ST_MISS;
                        end
                    endcase
                end
            end

            S_PUSH: begin
                // Take the free slot; its link is the new free head
                n_free         = w_rsp.link;
                w_req.val_we   = 1'b1;
                w_req.val_addr = r_free;
                w_req.val_data = r_val;
                if (r_count == '0) begin
                    n_head = r_free;
                    n_tail = r_free;
                end else if (r_op == bll_pkg::OP_PUSH_BACK) begin
                    w_req.lnk_we   = 1'b1;
                    w_req.lnk_addr = r_tail;
                    w_req.lnk_data = r_free;
                    n_tail         = r_free;
                end else begin
                    w_req.lnk_we   = 1'b1;
                    w_req.lnk_addr = r_free;
                    w_req.lnk_data = r_head;
                    n_head         = r_free;
                end
                n_count  = r_count + bll_pkg::CW'(1);
                n_done   = 1'b1;
                n_status = bll_pkg::ST_OK;
                n_state  = S_IDLE;
            end

            S_POP: begin
                // Unhook the head, then release it
                n_rv    = w_rsp.value;
                n_head  = w_rsp.link;
                n_slot  = r_head;
                n_state = S_FREE;
            end

            S_WALK: begin
                if (w_match) begin
                    case (r_op)
                        bll_pkg::OP_REMOVE: begin
                            if (r_idx == '0) begin
                                n_head = w_rsp.link;
                            end else begin
                                w_req.lnk_we   = 1'b1;
                                w_req.lnk_addr = r_prev;
                                w_req.lnk_data = w_rsp.link;
                                if (r_slot == r_tail) begin
                                    n_tail = r_prev;
                                end
                            end
                            n_state = S_FREE;
                        end
                        bll_pkg::OP_GET: begin
                            n_rv     = w_rsp.value;
                            n_done   = 1'b1;
                            n_status = bll_pkg::ST_OK;
                            n_state  = S_IDLE;
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_status = bll_pkg::ST_OK;
                            n_state  = S_IDLE;
                        end
                    endcase
                end else if (w_idx_inc >= r_count) begin
                    // Ran off the tail without a match
                    n_done   = 1'b1;
                    n_status = bll_pkg::ST_MISS;
                    n_state  = S_IDLE;
                end else begin
                    // Advance; the read of the next node is already issued
                    n_prev = r_slot;
                    n_slot = w_rsp.link;
                    n_idx  = r_idx + bll_pkg::AW'(1);
                end
            end

            S_FREE: begin
                // Return the slot to the head of the free list
                w_req.lnk_we   = 1'b1;
                w_req.lnk_addr = r_slot;
                w_req.lnk_data = r_free;
                n_free         = r_slot;
                n_count        = r_count - bll_pkg::CW'(1);
                n_done         = 1'b1;
                n_status       = bll_pkg::ST_OK;
                n_state        = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_free  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_free  <= n_free;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // Request and result payload: no reset needed
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_val    <= n_val;
        r_pos    <= n_pos;
        r_slot   <= n_slot;
        r_prev   <= n_prev;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_rv     <= n_rv;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_read_value = $signed(r_rv);
    assign o_length     = bll_pkg::LEN_W'(r_count);

`ifndef SYNTHESIS
    // An accepted request either answers at once or starts work
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state != S_IDLE || o_done))
        else $error("accepted request neither answered nor started");

    // A result only appears once the sequencer is back in idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_state == S_IDLE))
        else $error("result strobe while sequencer busy");

    // Full is reported only when the store really is full
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == bll_pkg::ST_FULL) |->
            (r_count == bll_pkg::CW'(bll_pkg::DEPTH)))
        else $error("full status with room left");

    // The walk never steps past the last element
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (bll_pkg::CW'(r_idx) < r_count))
        else $error("walk index beyond list length");

    // A successful push leaves a nonempty list
    a_push_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == bll_pkg::ST_OK &&
         (r_op == bll_pkg::OP_PUSH_BACK || r_op == bll_pkg::OP_PUSH_FRONT)) |->
            (o_length != '0))
        else $error("push reported done with empty list");
`endif

endmodule

`default_nettype wire

// File: rtl/bll_node_store.sv
// ============================================================================
// bll_node_store: node value and link memories
// One write port per memory and one shared read address; read data is
// registered. Links read as slot+1, wrapping to 0 at the last slot, until written.
// ============================================================================
`default_nettype none

module bll_node_store (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire bll_pkg::t_store_req i_req,
    output bll_pkg::t_store_rsp      o_rsp
);

    logic [bll_pkg::VAL_W-1:0] r_val_mem [bll_pkg::DEPTH];
    logic [bll_pkg::AW-1:0]    r_lnk_mem [bll_pkg::DEPTH];
    logic [bll_pkg::DEPTH-1:0] r_lnk_vld;

    logic [bll_pkg::AW-1:0]    r_rd_addr;
    logic [bll_pkg::VAL_W-1:0] r_val_q;
    logic [bll_pkg::AW-1:0]    r_lnk_q;
    logic                      r_vld_q;
    logic [bll_pkg::AW-1:0]    w_dflt_link;

    always_ff @(posedge i_clk) begin
        if (i_req.val_we) begin
            r_val_mem[i_req.val_addr] <= i_req.val_data;
        end
        r_val_q <= r_val_mem[i_req.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.lnk_we) begin
            r_lnk_mem[i_req.lnk_addr] <= i_req.lnk_data;
        end
        r_lnk_q   <= r_lnk_mem[i_req.rd_addr];
        r_rd_addr <= i_req.rd_addr;
    end

    // Track which links have been written since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lnk_vld <= '0;
            r_vld_q   <= 1'b0;
        end else begin
            if (i_req.lnk_we) begin
                r_lnk_vld[i_req.lnk_addr] <= 1'b1;
            end
            r_vld_q <= r_lnk_vld[i_req.rd_addr];
        end
    end

    // Unwritten link: next slot, wrapping at the end of the store
    assign w_dflt_link = (r_rd_addr == bll_pkg::AW'(bll_pkg::DEPTH - 1)) ? '0
                       : r_rd_addr + bll_pkg::AW'(1);

    assign o_rsp.value = r_val_q;
    assign o_rsp.link  = r_vld_q ? r_lnk_q : w_dflt_link;

endmodule

`default_nettype wire

// File: dv/bounded_linked_list_engine_tb.sv
// ============================================================================
// bounded_linked_list_engine_tb: self-checking bench for the list engine
// Drive push, pop, remove, contains and get requests through the start/busy
// handshake and check each one-cycle reply against a behavioral copy of the
// node store, its links and its free list. A short directed part covers
// the edge cases. Random phases with different sender idling follow, each
// with a burst that fills the list past its capacity.
// ============================================================================
module bounded_linked_list_engine_tb;

    // Reserved command codes: the engine must ignore them and answer a miss
    localparam logic [bll_pkg::OP_W-1:0]  OP_RSVD_6 = 3'd6;
    localparam logic [bll_pkg::OP_W-1:0]  OP_RSVD_7 = 3'd7;
    localparam logic [bll_pkg::POS_W-1:0] LAST_POS  = bll_pkg::POS_W'(bll_pkg::DEPTH - 1);

    localparam int CLK_HALF     = 6;
    localparam int RST_CYCLES   = 12;
    localparam int SINGLES      = 110;   // random requests per phase
    localparam int DRAIN_CYCLES = 80;    // margin after the last reply
    localparam int LIMIT_CYCLES = 400_000;

    typedef struct {
        logic [bll_pkg::OP_W-1:0]         op;
        logic signed [bll_pkg::VAL_W-1:0] value;
        logic [bll_pkg::POS_W-1:0]        position;
        int                               idle_pct;
    } t_list_cmd;

    typedef struct {
        logic [bll_pkg::ST_W-1:0]         status;
        logic signed [bll_pkg::VAL_W-1:0] value;
        logic [bll_pkg::LEN_W-1:0]        length;
    } t_list_reply;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             start;
    logic                             busy;
    logic [bll_pkg::OP_W-1:0]         i_operation;
    logic signed [bll_pkg::VAL_W-1:0] i_value;
    logic [bll_pkg::POS_W-1:0]        i_position;
    logic                             o_done;
    logic [bll_pkg::ST_W-1:0]         o_status;
    logic signed [bll_pkg::VAL_W-1:0] o_read_value;
    logic [bll_pkg::LEN_W-1:0]        o_length;

    bounded_linked_list_engine dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_operation  (i_operation),
        .i_value      (i_value),
        .i_position   (i_position),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_read_value (o_read_value),
        .o_length     (o_length)
    );

    // Requests waiting to be issued, and replies owed by the engine
    t_list_cmd   cmd_backlog[$];
    t_list_reply expected_replies[$];
    int          issued_cmds;
    int          accepted_cmds;
    int          reply_count;
    int          error_count;
    int          cur_idle_pct;
    logic        req_taken;

    // Shadow node store: values, next links, list ends, free list, length
    logic signed [bll_pkg::VAL_W-1:0] node_val [bll_pkg::DEPTH];
    logic [bll_pkg::AW-1:0]           node_nxt [bll_pkg::DEPTH];
    logic [bll_pkg::AW-1:0]           list_head;
    logic [bll_pkg::AW-1:0]           list_tail;
    logic [bll_pkg::AW-1:0]           free_head;
    logic [bll_pkg::CW-1:0]           list_len;

    // A few values reused often, so that searches hit and duplicates occur
    logic signed [bll_pkg::VAL_W-1:0] value_pool [8] = '{16'sh8000, 16'sh7fff, 16'sd0,
                                                         -16'sd1, 16'sd1, 16'sd42,
                                                         -16'sd300, 16'sd12345};

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Bring the shadow store to its reset state: empty list, free chain in order
    task automatic list_clear();
        for (int i = 0; i < bll_pkg::DEPTH; i++) begin
            node_val[i] = '0;
            node_nxt[i] = bll_pkg::AW'((i + 1) % bll_pkg::DEPTH);
        end
        list_head = '0;
        list_tail = '0;
        free_head = '0;
        list_len  = '0;
    endtask

    // Apply one request to the shadow store and produce the reply it owes
    task automatic list_apply(input logic [bll_pkg::OP_W-1:0] op,
                              input logic signed [bll_pkg::VAL_W-1:0] val,
                              input logic [bll_pkg::POS_W-1:0] pos,
                              output t_list_reply r);
        logic [bll_pkg::AW-1:0] slot;
        logic [bll_pkg::AW-1:0] prev;
        bit                     hit;
        r.status = bll_pkg::ST_MISS;
        r.value  = '0;
        hit      = 1'b0;
        slot     = list_head;
        prev     = list_head;
        case (op)
            bll_pkg::OP_PUSH_BACK, bll_pkg::OP_PUSH_FRONT: begin
                if (list_len >= bll_pkg::CW'(bll_pkg::DEPTH)) begin
                    r.status = bll_pkg::ST_FULL;
                end else begin
                    // take the first free node
                    slot           = free_head;
                    free_head      = node_nxt[slot];
                    node_val[slot] = val;
                    if (list_len == 0) begin
                        list_head = slot;
                        list_tail = slot;
                    end else if (op == bll_pkg::OP_PUSH_BACK) begin
                        node_nxt[list_tail] = slot;
                        list_tail           = slot;
                    end else begin
                        node_nxt[slot] = list_head;
                        list_head      = slot;
                    end
                    list_len++;
                    r.status = bll_pkg::ST_OK;
                end
            end
            bll_pkg::OP_POP_FRONT: begin
                if (list_len != 0) begin
                    r.value        = node_val[slot];
                    list_head      = node_nxt[slot];
                    node_nxt[slot] = free_head;
                    free_head      = slot;
                    list_len--;
                    r.status = bll_pkg::ST_OK;
                end
            end
            bll_pkg::OP_REMOVE: begin
                for (int k = 0; k < list_len && !hit; k++) begin
                    if (node_val[slot] == val) begin
                        hit = 1'b1;
                        if (k == 0) begin
                            list_head = node_nxt[slot];
                        end else begin
                            node_nxt[prev] = node_nxt[slot];
                            if (slot == list_tail)
                                list_tail = prev;
                        end
                        // return the node to the front of the free list
                        node_nxt[slot] = free_head;
                        free_head      = slot;
                        list_len--;
                        r.status = bll_pkg::ST_OK;
                    end else begin
                        prev = slot;
                        slot = node_nxt[slot];
                    end
                end
            end
            bll_pkg::OP_CONTAINS: begin
                for (int k = 0; k < list_len && !hit; k++) begin
                    if (node_val[slot] == val)
                        hit = 1'b1;
                    else
                        slot = node_nxt[slot];
                end
                if (hit)
                    r.status = bll_pkg::ST_OK;
            end
            bll_pkg::OP_GET: begin
                if (pos < list_len) begin
                    for (int k = 0; k < pos; k++)
                        slot = node_nxt[slot];
                    r.value  = node_val[slot];
                    r.status = bll_pkg::ST_OK;
                end
            end
            default: begin
                // reserved code: leave the list alone
            end
        endcase
        r.length = bll_pkg::LEN_W'(list_len);
    endtask

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("[%0t] reply %0d: %s expected %0d, got %0d", $time, reply_count, what,
                 want, got);
        error_count++;
    endtask

    task automatic add_cmd(input logic [bll_pkg::OP_W-1:0] op,
                           input logic signed [bll_pkg::VAL_W-1:0] val,
                           input logic [bll_pkg::POS_W-1:0] pos);
        t_list_cmd c;
        c.op       = op;
        c.value    = val;
        c.position = pos;
        c.idle_pct = cur_idle_pct;
        cmd_backlog.push_back(c);
        issued_cmds++;
    endtask

    function automatic logic signed [bll_pkg::VAL_W-1:0] pick_value();
        if ($urandom_range(99) < 60)
            return value_pool[$urandom_range(7)];
        return bll_pkg::VAL_W'($urandom);
    endfunction

    function automatic logic [bll_pkg::POS_W-1:0] pick_position();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70)
            return bll_pkg::POS_W'($urandom_range(7));
        if (r < 95)
            return bll_pkg::POS_W'($urandom_range(bll_pkg::DEPTH - 1));
        return LAST_POS;
    endfunction

    // One random request; pops and removes together outweigh pushes so the list stays short
    task automatic add_random_cmd();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 13)
            add_cmd(bll_pkg::OP_PUSH_BACK, pick_value(), pick_position());
        else if (r < 25)
            add_cmd(bll_pkg::OP_PUSH_FRONT, pick_value(), pick_position());
        else if (r < 47)
            add_cmd(bll_pkg::OP_POP_FRONT, pick_value(), pick_position());
        else if (r < 62)
            add_cmd(bll_pkg::OP_REMOVE, pick_value(), pick_position());
        else if (r < 75)
            add_cmd(bll_pkg::OP_CONTAINS, pick_value(), pick_position());
        else if (r < 96)
            add_cmd(bll_pkg::OP_GET, pick_value(), pick_position());
        else
            add_cmd($urandom_range(1) ? OP_RSVD_7 : OP_RSVD_6, pick_value(), pick_position());
    endtask

    // Fill past capacity, then probe the full list: last index, refused pushes,
    // a search across every node, a removal from a full store, a pop and a late get
    task automatic add_fill_burst();
        for (int n = 0; n < bll_pkg::DEPTH + 2; n++)
            add_cmd($urandom_range(1) ? bll_pkg::OP_PUSH_FRONT : bll_pkg::OP_PUSH_BACK,
                    pick_value(), pick_position());
        add_cmd(bll_pkg::OP_GET, pick_value(), LAST_POS);
        add_cmd(bll_pkg::OP_GET, pick_value(), '0);
        add_cmd(bll_pkg::OP_PUSH_BACK, pick_value(), pick_position());
        add_cmd(bll_pkg::OP_PUSH_FRONT, pick_value(), pick_position());
        add_cmd(bll_pkg::OP_CONTAINS, bll_pkg::VAL_W'($urandom), pick_position());
        add_cmd(bll_pkg::OP_REMOVE, value_pool[$urandom_range(7)], pick_position());
        add_cmd(bll_pkg::OP_POP_FRONT, pick_value(), pick_position());
        add_cmd(bll_pkg::OP_GET, pick_value(), bll_pkg::POS_W'(bll_pkg::DEPTH - 3));
    endtask

    // Driver: present the next request on the falling edge, hold it while busy
    always @(negedge i_clk) begin : drive_proc
        t_list_cmd nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !req_taken) begin
            // hold: the engine has not taken the request yet
        end else if (cmd_backlog.size() != 0 &&
                     $urandom_range(99) >= cmd_backlog[0].idle_pct) begin
            nxt = cmd_backlog.pop_front();
            start       <= 1'b1;
            i_operation <= nxt.op;
            i_value     <= nxt.value;
            i_position  <= nxt.position;
        end else begin
            start <= 1'b0;
        end
    end

    // Monitor: check the reply strobe first, then predict any request taken
    // on the same edge (a new request may be issued in the reply cycle)
    always @(posedge i_clk) begin : watch_proc
        t_list_reply want;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= start && !busy;
            if (o_done) begin
                if (expected_replies.size() == 0) begin
                    report_mismatch("reply with no request pending, status", -1,
                                    int'(o_status));
                end else begin
                    want = expected_replies.pop_front();
                    if (o_status !== want.status)
                        report_mismatch("status", int'(want.status), int'(o_status));
                    if (o_read_value !== want.value)
                        report_mismatch("read_value", int'(want.value), int'(o_read_value));
                    if (o_length !== want.length)
                        report_mismatch("length", int'(want.length), int'(o_length));
                end
                reply_count++;
            end
            if (start && !busy) begin
                list_apply(i_operation, i_value, i_position, want);
                expected_replies.push_back(want);
                accepted_cmds++;
            end
        end
    end

    // Stimulus and end of run
    initial begin : stim_proc
        int phase_idle [4];
        // Sender idling per phase; the third phase stands for receiver stalls,
        // which this engine does not allow, so it runs without gaps
        phase_idle = '{0, 59, 0, 10};
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_operation   = bll_pkg::OP_PUSH_BACK;
        i_value       = '0;
        i_position    = '0;
        issued_cmds   = 0;
        accepted_cmds = 0;
        reply_count   = 0;
        error_count   = 0;
        cur_idle_pct  = 0;
        list_clear();

        // Empty-list misses
        add_cmd(bll_pkg::OP_POP_FRONT, 16'sd0, '0);
        add_cmd(bll_pkg::OP_REMOVE, 16'sd5, '0);
        add_cmd(bll_pkg::OP_CONTAINS, 16'sd0, '0);
        add_cmd(bll_pkg::OP_GET, 16'sd0, '0);
        // Build -1, 0, -32768, 32767 from both ends with the value extremes
        add_cmd(bll_pkg::OP_PUSH_BACK, 16'sh8000, '0);
        add_cmd(bll_pkg::OP_PUSH_BACK, 16'sd32767, LAST_POS);
        add_cmd(bll_pkg::OP_PUSH_FRONT, 16'sd0, '0);
        add_cmd(bll_pkg::OP_PUSH_FRONT, -16'sd1, LAST_POS);
        // Reads: head, last valid index, one past the end, far out of range
        add_cmd(bll_pkg::OP_GET, 16'sd0, '0);
        add_cmd(bll_pkg::OP_GET, 16'sd0, bll_pkg::POS_W'(3));
        add_cmd(bll_pkg::OP_GET, 16'sd0, bll_pkg::POS_W'(4));
        add_cmd(bll_pkg::OP_GET, -16'sd1, LAST_POS);
        add_cmd(bll_pkg::OP_CONTAINS, 16'sd32767, '0);
        add_cmd(bll_pkg::OP_CONTAINS, 16'sd1234, '0);
        // Remove the tail, then push back to prove the tail moved
        add_cmd(bll_pkg::OP_REMOVE, 16'sd32767, '0);
        add_cmd(bll_pkg::OP_PUSH_BACK, 16'sd7, '0);
        add_cmd(bll_pkg::OP_REMOVE, 16'sd0, '0);
        add_cmd(bll_pkg::OP_REMOVE, -16'sd1, '0);
        add_cmd(bll_pkg::OP_REMOVE, 16'sd999, '0);
        add_cmd(OP_RSVD_6, -16'sd1, LAST_POS);
        add_cmd(OP_RSVD_7, 16'sd0, '0);
        add_cmd(bll_pkg::OP_POP_FRONT, 16'sd0, '0);
        add_cmd(bll_pkg::OP_POP_FRONT, 16'sd0, '0);
        add_cmd(bll_pkg::OP_POP_FRONT, 16'sd0, '0);

        for (int p = 0; p < 4; p++) begin
            cur_idle_pct = phase_idle[p];
            for (int n = 0; n < SINGLES / 2; n++)
                add_random_cmd();
            add_fill_burst();
            for (int n = 0; n < SINGLES / 2; n++)
                add_random_cmd();
        end

        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Advance until every request is taken and every reply has come back
        while (accepted_cmds < issued_cmds || expected_replies.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("** bounded_linked_list_engine: PASSED **");
        else
            $display("** bounded_linked_list_engine: FAILED **");
        $finish;
    end

    // Watchdog: drop the run if the engine stops answering
    initial begin
        #(2 * CLK_HALF * LIMIT_CYCLES);
        $display("timeout: %0d of %0d requests taken, %0d replies owed", accepted_cmds,
                 issued_cmds, expected_replies.size());
        $display("** bounded_linked_list_engine: FAILED **");
        $finish;
    end

endmodule
